FILE: rtl/core/pulse_burst_capture_stats_top_assert.svh
// Assertion macros shared by the pulse burst capture blocks.
// No dependencies; the files that check themselves include this header.
`ifndef PULSE_BURST_CAPTURE_STATS_TOP_ASSERT_SVH
`define PULSE_BURST_CAPTURE_STATS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PBCS_ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pbcs: invariant violated");

`define PBCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbcs: implication violated");

`define PBCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbcs: next-cycle check violated");

`else

`define PBCS_ASSERT_HOLDS(label, clk, rst, cond)
`define PBCS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PBCS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/pbcs_pkg.sv
// Shared types and constants for the pulse burst capture block.
// No dependencies.
package pbcs_pkg;

   localparam int FIELD_BITS = 32;
   localparam int SUM_BITS   = 48;
   localparam int COUNT_BITS = 16;
   localparam int DIV_STEPS  = SUM_BITS;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);

   localparam logic [FIELD_BITS-1:0] TIMEOUT_RESET = 32'd500000000;

   localparam logic KIND_PERIOD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam int FIXED_BITS = 2 + SUM_BITS + COUNT_BITS;

   typedef struct packed {
      logic                  kind;
      logic                  level;
      logic [SUM_BITS-1:0]   low_sum;
      logic [COUNT_BITS-1:0] low_count;
   } event_fixed_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/core/pbcs_front.sv
// Front end: tracks the line per sample, keeps burst statistics and
// queues period reports and summary requests. Uses pbcs_pkg.
`include "pulse_burst_capture_stats_top_assert.svh"

module pbcs_front #(
   parameter int TIME_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_line_level,
   input  logic [31:0]                timeout_ticks,
   input  pbcs_pkg::queue_status_type q_status,
   output logic                       ev_push,
   output pbcs_pkg::event_fixed_type  ev_fixed,
   output logic [TIME_BITS-1:0]       ev_time
);

   localparam int CW  = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int SW  = pbcs_pkg::SUM_BITS;
   localparam int SW1 = pbcs_pkg::SUM_BITS + 1;
   localparam int NW  = pbcs_pkg::COUNT_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [NW-1:0]        COUNT_MAX = '1;

   logic                 capturing_ff, capturing_in;
   logic                 held_ff, held_in;
   logic [TIME_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0] longest_ff, longest_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [NW-1:0]        count_ff, count_in;

   logic                 accept;
   logic [TIME_BITS-1:0] el_inc;
   logic [SW1-1:0]       sum_add;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign el_inc    = (elapsed_ff == TIME_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign sum_add   = {1'b0, sum_ff} + SW1'(elapsed_ff);

   always_comb begin
      capturing_in = capturing_ff;
      held_in      = held_ff;
      elapsed_in   = elapsed_ff;
      longest_in   = longest_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ev_push      = 1'b0;
      ev_fixed     = '0;
      ev_time      = '0;
      if (accept) begin
         priority if (!capturing_ff) begin
            if (!req_line_level) begin
               capturing_in = 1'b1;
               held_in      = 1'b0;
               elapsed_in   = TIME_BITS'(1);
            end
         end else if (req_line_level != held_ff) begin
            ev_push        = 1'b1;
            ev_fixed.kind  = pbcs_pkg::KIND_PERIOD;
            ev_fixed.level = held_ff;
            ev_time        = elapsed_ff;
            if (!held_ff) begin
               if (elapsed_ff > longest_ff) begin
                  longest_in = elapsed_ff;
               end
               sum_in = sum_add[SW] ? '1 : sum_add[SW-1:0];
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end
            held_in    = req_line_level;
            elapsed_in = TIME_BITS'(1);
         end else begin
            elapsed_in = el_inc;
            if (held_ff && (CW'(el_inc) > CW'(timeout_ticks))) begin
               ev_push            = 1'b1;
               ev_fixed.kind      = pbcs_pkg::KIND_SUMMARY;
               ev_fixed.low_sum   = sum_ff;
               ev_fixed.low_count = count_ff;
               ev_time            = longest_ff;
               capturing_in       = 1'b0;
               held_in            = 1'b0;
               elapsed_in         = '0;
               longest_in         = '0;
               sum_in             = '0;
               count_in           = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         held_ff      <= 1'b0;
         elapsed_ff   <= '0;
         longest_ff   <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         capturing_ff <= capturing_in;
         held_ff      <= held_in;
         elapsed_ff   <= elapsed_in;
         longest_ff   <= longest_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
      end
   end

   `PBCS_ASSERT_IMPLIES(a_idle_clear, clock, reset, !capturing_ff, elapsed_ff == '0 && sum_ff == '0 && count_ff == '0)
   `PBCS_ASSERT_IMPLIES(a_burst_counts, clock, reset, capturing_ff, elapsed_ff != '0)
   `PBCS_ASSERT_NEXT(a_summary_rearms, clock, reset, ev_push && ev_fixed.kind == pbcs_pkg::KIND_SUMMARY, !capturing_ff)

endmodule

FILE: rtl/core/pbcs_queue.sv
// Short first-in first-out queue between front and back ends.
// Uses pbcs_pkg for the status struct.
module pbcs_queue #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output pbcs_pkg::queue_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CB = $clog2(DEPTH + 1);
   localparam logic [CB-1:0] FULL_COUNT = CB'(DEPTH);
   localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0]    count_ff;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/core/pbcs_back.sv
// Back end: turns queued events into results; summaries go through a
// radix-2 restoring divider for the average. Uses pbcs_pkg.
`include "pulse_burst_capture_stats_top_assert.svh"

module pbcs_back #(
   parameter int TIME_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pbcs_pkg::queue_status_type q_status,
   input  pbcs_pkg::event_fixed_type ev_fixed,
   input  logic [TIME_BITS-1:0]      ev_time,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_result_kind,
   output logic [31:0]               rsp_period_ticks,
   output logic                      rsp_period_level,
   output logic [31:0]               rsp_average_low_ticks,
   output logic [31:0]               rsp_longest_low_ticks,
   output logic [15:0]               rsp_low_period_count
);

   localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int SW = pbcs_pkg::SUM_BITS;
   localparam int NW = pbcs_pkg::COUNT_BITS;
   localparam int TW = pbcs_pkg::COUNT_BITS + 1;
   localparam int PB = pbcs_pkg::STEP_BITS;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   function automatic logic [31:0] clamp_time(input logic [TIME_BITS-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      return (ext > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
   endfunction

   back_state_type       state_ff, state_in;
   logic [PB-1:0]        step_ff, step_in;
   logic [NW-1:0]        rem_ff, rem_in;
   logic [SW-1:0]        quo_ff, quo_in;
   logic [NW-1:0]        div_ff, div_in;
   logic [TIME_BITS-1:0] longest_ff, longest_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] ticks_ff, ticks_in;
   logic        level_ff, level_in;
   logic [31:0] avg_ff, avg_in;
   logic [31:0] long_out_ff, long_out_in;
   logic [15:0] cnt_out_ff, cnt_out_in;

   logic          out_free;
   logic [TW-1:0] trial, diff;
   logic          ge;
   logic [31:0]   quo_clamped;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = (state_ff == BK_IDLE) && out_free && !q_status.empty;
   assign trial       = {rem_ff, quo_ff[SW-1]};
   assign diff        = trial - {1'b0, div_ff};
   assign ge          = (trial >= {1'b0, div_ff});
   assign quo_clamped = (|quo_ff[SW-1:32]) ? 32'hFFFF_FFFF : quo_ff[31:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_in       = div_ff;
      longest_in   = longest_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      ticks_in     = ticks_ff;
      level_in     = level_ff;
      avg_in       = avg_ff;
      long_out_in  = long_out_ff;
      cnt_out_in   = cnt_out_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               if (ev_fixed.kind == pbcs_pkg::KIND_PERIOD) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = pbcs_pkg::KIND_PERIOD;
                  ticks_in     = clamp_time(ev_time);
                  level_in     = ev_fixed.level;
                  avg_in       = '0;
                  long_out_in  = '0;
                  cnt_out_in   = '0;
               end else begin
                  state_in   = BK_DIV;
                  step_in    = '0;
                  rem_in     = '0;
                  quo_in     = ev_fixed.low_sum;
                  div_in     = ev_fixed.low_count;
                  longest_in = ev_time;
               end
            end
         end
         BK_DIV: begin
            rem_in  = ge ? diff[NW-1:0] : trial[NW-1:0];
            quo_in  = {quo_ff[SW-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == pbcs_pkg::STEP_LAST) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               kind_in      = pbcs_pkg::KIND_SUMMARY;
               ticks_in     = '0;
               level_in     = 1'b0;
               avg_in       = (div_ff == '0) ? '0 : quo_clamped;
               long_out_in  = clamp_time(longest_ff);
               cnt_out_in   = div_ff;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      longest_ff  <= longest_in;
      kind_ff     <= kind_in;
      ticks_ff    <= ticks_in;
      level_ff    <= level_in;
      avg_ff      <= avg_in;
      long_out_ff <= long_out_in;
      cnt_out_ff  <= cnt_out_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = kind_ff;
   assign rsp_period_ticks      = ticks_ff;
   assign rsp_period_level      = level_ff;
   assign rsp_average_low_ticks = avg_ff;
   assign rsp_longest_low_ticks = long_out_ff;
   assign rsp_low_period_count  = cnt_out_ff;

   `PBCS_ASSERT_IMPLIES(a_summary_fields, clock, reset, rsp_valid_ff && kind_ff == pbcs_pkg::KIND_SUMMARY, ticks_ff == '0 && !level_ff)
   `PBCS_ASSERT_IMPLIES(a_period_fields, clock, reset, rsp_valid_ff && kind_ff == pbcs_pkg::KIND_PERIOD, avg_ff == '0 && long_out_ff == '0 && cnt_out_ff == '0)
   `PBCS_ASSERT_NEXT(a_div_progress, clock, reset, state_ff == BK_DIV, state_ff == BK_DIV || state_ff == BK_DONE)

endmodule

FILE: rtl/core/pulse_burst_capture_stats_top.sv
// Channel  Ports                         Direction  Handshake
// req      req_line_level                in         req_valid / req_stall
// rsp      rsp_result_kind .. count      out        rsp_valid / rsp_stall
// csr      csr_timeout_ticks             in         csr_valid / csr_ready
//
// One sample a cycle while the event queue has room; req_stall rises when it fills.
// A period report reaches rsp in the cycle after it leaves the queue.
// In the back end a burst summary passes from BK_IDLE through BK_DIV, the serial 48/16 divider, to BK_DONE.
// Reset is synchronous, needs no clearing pass; csr_ready is always high.
// Uses pbcs_pkg, pbcs_front, pbcs_queue and pbcs_back.
module pulse_burst_capture_stats_top #(
   parameter int TIME_BITS   = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_period_ticks,
   output logic        rsp_period_level,
   output logic [31:0] rsp_average_low_ticks,
   output logic [31:0] rsp_longest_low_ticks,
   output logic [15:0] rsp_low_period_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_timeout_ticks
);

   localparam int QW = pbcs_pkg::FIXED_BITS + TIME_BITS;

   logic [31:0] timeout_ff;

   pbcs_pkg::queue_status_type q_status;
   pbcs_pkg::event_fixed_type  push_fixed, pop_fixed;
   logic [TIME_BITS-1:0]       push_time, pop_time;
   logic                       push, pop;
   logic [QW-1:0]              pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= pbcs_pkg::TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_timeout_ticks;
      end
   end

   pbcs_front #(
      .TIME_BITS(TIME_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_line_level (req_line_level),
      .timeout_ticks  (timeout_ff),
      .q_status       (q_status),
      .ev_push        (push),
      .ev_fixed       (push_fixed),
      .ev_time        (push_time)
   );

   pbcs_queue #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_fixed, push_time}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   assign pop_fixed = pop_data[QW-1:TIME_BITS];
   assign pop_time  = pop_data[TIME_BITS-1:0];

   pbcs_back #(
      .TIME_BITS(TIME_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_status              (q_status),
      .ev_fixed              (pop_fixed),
      .ev_time               (pop_time),
      .q_pop                 (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_period_ticks      (rsp_period_ticks),
      .rsp_period_level      (rsp_period_level),
      .rsp_average_low_ticks (rsp_average_low_ticks),
      .rsp_longest_low_ticks (rsp_longest_low_ticks),
      .rsp_low_period_count  (rsp_low_period_count)
   );

endmodule
